// ----- src/cfsa_pkg.sv -----
`default_nettype none

package cfsa_pkg;

    // Table size and field widths
    localparam int DEFAULT_SLOTS = 16;
    localparam int SLOT_FIELD_W  = 4;
    localparam int ID_W          = 16;
    localparam int BUS_W         = 2;
    localparam int DLC_W         = 5;
    localparam int IVL_W         = 16;

    // Signal rules
    localparam logic [IVL_W-1:0] DEFAULT_INTERVAL = IVL_W'(100);
    localparam logic [7:0]       MAX_BITS         = 8'd64;
    localparam int               BYTE_SHIFT       = 3;   // eight bits per byte

    // Operation codes
    localparam logic OP_CLEAR = 1'b0;
    localparam logic OP_ADD   = 1'b1;

    // Request from the upstream side
    typedef struct packed {
        logic              operation;
        logic              enabled;
        logic              extended;
        logic [ID_W-1:0]   can_id;
        logic [BUS_W-1:0]  bus;
        logic [5:0]        start_bit;
        logic [7:0]        bit_length;
        logic [IVL_W-1:0]  interval;
    } t_req;

    // Result towards the downstream side
    typedef struct packed {
        logic                     assigned;
        logic [SLOT_FIELD_W-1:0]  slot;
        logic [DLC_W-1:0]         frame_dlc;
        logic [IVL_W-1:0]         frame_interval;
    } t_rsp;

    // Token walking along the slot chain; once assigned, dlc and interval
    // carry the slot's values after the update
    typedef struct packed {
        logic                     valid;
        logic                     done;
        logic                     assigned;
        logic                     extended;
        logic [ID_W-1:0]          can_id;
        logic [BUS_W-1:0]         bus;
        logic [SLOT_FIELD_W-1:0]  slot;
        logic [DLC_W-1:0]         dlc;
        logic [IVL_W-1:0]         interval;
    } t_token;

endpackage

`default_nettype wire

// ----- src/can_frame_slot_assigner.sv -----
`default_nettype none

// Channel   Direction  Handshake                   Payload
// request   in         i_req_valid / o_req_stall   i_req (t_req)
// result    out        o_rsp_valid / i_rsp_stall   o_rsp (t_rsp)
//
// One request is in the slot chain at a time; it steps through one slot cell
// per cycle from acceptance until it reaches the pending register, and moves
// on to the output register when that is empty or not stalled.
// A new request is taken only after the previous result has moved on.
// A new request is taken while an earlier result still waits downstream.
// Reset frees every slot at once; no clearing pass is needed.
// A stalled result holds the output register and keeps the following result
// in a pending register until it can move on.

module can_frame_slot_assigner #(
    parameter int SLOTS = cfsa_pkg::DEFAULT_SLOTS
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_req_valid,
    output logic           o_req_stall,
    input  cfsa_pkg::t_req i_req,
    output logic           o_rsp_valid,
    input  wire            i_rsp_stall,
    output cfsa_pkg::t_rsp o_rsp
);
    import cfsa_pkg::*;

    logic             r_busy;
    logic             r_pend_valid;
    t_rsp             r_pend;
    logic             r_out_valid;
    t_rsp             r_out;

    logic             w_accept;
    logic             w_clear;
    logic             w_ok;
    logic [7:0]       w_last_bit;
    logic [DLC_W-1:0] w_code;
    t_token           w_head;
    t_token           w_tok [SLOTS+1];
    logic [SLOTS-1:0] w_used;
    logic [SLOTS-1:0] w_tok_valid;
    t_token           w_tail;
    logic             w_move;

    assign w_accept    = i_req_valid && !r_busy;
    assign o_req_stall = r_busy;
    assign w_clear     = w_accept && (i_req.operation == OP_CLEAR);

    // Length code and validity of an add request
    assign w_last_bit = {2'b00, i_req.start_bit} + i_req.bit_length - 8'd1;
    assign w_code     = DLC_W'(w_last_bit[7:BYTE_SHIFT]) + DLC_W'(1);
    assign w_ok       = i_req.enabled && (i_req.bit_length != 8'd0)
                        && (i_req.bit_length <= MAX_BITS);

    // Build the token entering the chain
    always_comb begin
        w_head          = '0;
        w_head.valid    = w_accept;
        w_head.extended = i_req.extended;
        w_head.can_id   = i_req.can_id;
        w_head.bus      = i_req.bus;
        w_head.dlc      = w_code;
        if (i_req.interval == '0) begin
            w_head.interval = DEFAULT_INTERVAL;
        end else begin
            w_head.interval = i_req.interval;
        end
        // A clear or a rejected signal goes through already finished
        if (i_req.operation == OP_CLEAR || !w_ok) begin
            w_head.done     = 1'b1;
            w_head.dlc      = '0;
            w_head.interval = '0;
        end
    end

    assign w_tok[0] = w_head;

    // Row of slot cells
    for (genvar k = 0; k < SLOTS; k++) begin : g_cell
        cfsa_cell #(
            .INDEX (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clear (w_clear),
            .i_tok   (w_tok[k]),
            .o_tok   (w_tok[k+1]),
            .o_used  (w_used[k])
        );
        assign w_tok_valid[k] = w_tok[k+1].valid;
    end

    assign w_tail = w_tok[SLOTS];
    assign w_move = r_pend_valid && (!r_out_valid || !i_rsp_stall);

    // Track the request in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_accept) begin
            r_busy <= 1'b1;
        end else if (w_move) begin
            r_busy <= 1'b0;
        end
    end

    // Catch the token leaving the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (w_tail.valid) begin
            r_pend_valid <= 1'b1;
        end else if (w_move) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tail.valid) begin
            if (w_tail.assigned) begin
                r_pend.assigned       <= 1'b1;
                r_pend.slot           <= w_tail.slot;
                r_pend.frame_dlc      <= w_tail.dlc;
                r_pend.frame_interval <= w_tail.interval;
            end else begin
                r_pend <= '0;
            end
        end
    end

    // Output register; hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_rsp_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out <= r_pend;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    // At most one request walks the chain
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_tok_valid) <= 1)
        else $error("more than one token in the slot chain");

    // Used slots always form a run from slot zero
    a_used_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot({1'b0, w_used} + {{SLOTS{1'b0}}, 1'b1}))
        else $error("free slot below a used slot");

    // A token leaving the chain never finds the pending register full
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tail.valid |-> !r_pend_valid)
        else $error("pending result overwritten");

    // Tokens and pending results belong to a request in flight
    a_busy_cover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_valid || ($countones(w_tok_valid) != 0)) |-> r_busy)
        else $error("work in flight while idle");

    // Every accepted request reaches the pending register after the chain
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> ##(SLOTS-1) w_tail.valid)
        else $error("token lost in the slot chain");

endmodule

`default_nettype wire

// ----- src/cfsa_cell.sv -----
`default_nettype none

module cfsa_cell #(
    parameter int INDEX = 0
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_clear,
    input  cfsa_pkg::t_token i_tok,
    output cfsa_pkg::t_token o_tok,
    output logic             o_used
);
    import cfsa_pkg::*;

    logic [DLC_W-1:0] r_len, n_len;
    logic [ID_W-1:0]  r_ident, n_ident;
    logic             r_ext, n_ext;
    logic [BUS_W-1:0] r_bus, n_bus;
    logic [IVL_W-1:0] r_period, n_period;
    t_token           r_tok, n_tok;

    logic w_used;
    logic w_match;

    assign w_used  = (r_len != '0);
    assign w_match = w_used && (r_ext == i_tok.extended) && (r_ident == i_tok.can_id)
                     && (r_bus == i_tok.bus);

    // Claim a free slot or merge into a matching one, else pass the token on
    always_comb begin
        n_len    = r_len;
        n_ident  = r_ident;
        n_ext    = r_ext;
        n_bus    = r_bus;
        n_period = r_period;
        n_tok    = i_tok;
        if (i_tok.valid && !i_tok.done) begin
            if (!w_used) begin
                n_len          = i_tok.dlc;
                n_ident        = i_tok.can_id;
                n_ext          = i_tok.extended;
                n_bus          = i_tok.bus;
                n_period       = i_tok.interval;
                n_tok.done     = 1'b1;
                n_tok.assigned = 1'b1;
                n_tok.slot     = SLOT_FIELD_W'(INDEX);
            end else if (w_match) begin
                if (r_len > i_tok.dlc) begin
                    n_len = r_len;
                end else begin
                    n_len = i_tok.dlc;
                end
                if (r_period > i_tok.interval) begin
                    n_period = i_tok.interval;
                end else begin
                    n_period = r_period;
                end
                n_tok.done     = 1'b1;
                n_tok.assigned = 1'b1;
                n_tok.slot     = SLOT_FIELD_W'(INDEX);
                n_tok.dlc      = n_len;
                n_tok.interval = n_period;
            end
        end
    end

    // Slot state; a clear frees the slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_len   <= '0;
            r_ident <= '0;
            r_ext   <= 1'b0;
            r_bus   <= '0;
        end else begin
            r_len   <= n_len;
            r_ident <= n_ident;
            r_ext   <= n_ext;
            r_bus   <= n_bus;
        end
    end

    // Interval is only read for a used slot
    always_ff @(posedge i_clk) begin
        r_period <= n_period;
    end

    // Hand the token to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok  = r_tok;
    assign o_used = w_used;

endmodule

`default_nettype wire
